// File: sv/ntas_pkg.sv
// shared types, codes and helper functions for the n-dimensional typed array store
// no dependencies
`default_nettype none

package ntas_pkg;

   localparam int REG_DIMS = 4;
   localparam int DIMS = 4;
   localparam int DIM_LIMIT = (DIMS < REG_DIMS) ? DIMS : REG_DIMS;
   localparam int DEF_MEM_WORDS = 8192;
   localparam int DIM_W = 13;
   localparam int TOT_W = 4 * DIM_W;
   localparam int TB_W = TOT_W + 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [3:0] ET_S8       = 4'd0;
   localparam logic [3:0] ET_U8       = 4'd1;
   localparam logic [3:0] ET_S16      = 4'd2;
   localparam logic [3:0] ET_U16      = 4'd3;
   localparam logic [3:0] ET_S64      = 4'd4;
   localparam logic [3:0] ET_U64      = 4'd5;
   localparam logic [3:0] ET_F32      = 4'd6;
   localparam logic [3:0] ET_F64      = 4'd7;
   localparam logic [3:0] ET_NUM64    = 4'd8;
   localparam logic [3:0] ET_BYTEBOOL = 4'd9;
   localparam logic [3:0] ET_BITBOOL  = 4'd10;

   localparam logic [1:0] FN_SET   = 2'd0;
   localparam logic [1:0] FN_GET   = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;
   localparam logic [1:0] FN_NONE  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SIZE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] RI_ELEM_TYPE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] RI_NUM_DIMS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] RI_DIM_SIZE_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] RI_DIM_SIZE_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] RI_DIM_SIZE_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] RI_DIM_SIZE_3 = 3'd5;

   typedef logic [REG_DIMS-1:0][DIM_W-1:0] dim_vec_type;

   function automatic logic type_known(input logic [3:0] t);
      logic ok;
      ok = (t <= ET_BITBOOL);
      return ok;
   endfunction

   // log2 of the element width in bits
   function automatic logic [2:0] type_lg(input logic [3:0] t);
      logic [2:0] lg;
      case (t) inside
         ET_S8, ET_U8, ET_BYTEBOOL:        lg = 3'd3;
         ET_S16, ET_U16:                   lg = 3'd4;
         ET_F32:                           lg = 3'd5;
         ET_S64, ET_U64, ET_F64, ET_NUM64: lg = 3'd6;
         default:                          lg = 3'd0;
      endcase
      return lg;
   endfunction

   function automatic logic [63:0] width_mask(input logic [2:0] lg);
      logic [63:0] m;
      case (lg)
         3'd0:    m = 64'h1;
         3'd3:    m = 64'hFF;
         3'd4:    m = 64'hFFFF;
         3'd5:    m = 64'hFFFF_FFFF;
         default: m = '1;
      endcase
      return m;
   endfunction

   // element value replicated over every aligned slot of a word
   function automatic logic [63:0] fill_pattern(input logic [3:0] t, input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] p;
      v = ((t == ET_BYTEBOOL) || (t == ET_BITBOOL)) ? {63'd0, (val != 64'd0)} : val;
      case (type_lg(t))
         3'd0:    p = {64{v[0]}};
         3'd3:    p = {8{v[7:0]}};
         3'd4:    p = {4{v[15:0]}};
         3'd5:    p = {2{v[31:0]}};
         default: p = v;
      endcase
      return p;
   endfunction

   function automatic logic [63:0] extract_elem(input logic [3:0] t, input logic [63:0] word,
                                                input logic [5:0] sh);
      logic [63:0] raw;
      logic [63:0] res;
      raw = word >> sh;
      case (t)
         ET_S8:       res = {{56{raw[7]}}, raw[7:0]};
         ET_U8:       res = {56'd0, raw[7:0]};
         ET_S16:      res = {{48{raw[15]}}, raw[15:0]};
         ET_U16:      res = {48'd0, raw[15:0]};
         ET_F32:      res = {32'd0, raw[31:0]};
         ET_BYTEBOOL: res = {63'd0, (raw[7:0] != 8'd0)};
         ET_BITBOOL:  res = {63'd0, raw[0]};
         default:     res = raw;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/ntas_mem.sv
// word memory of the array store: one write port, one read port, registered read data
// depends on nothing
`default_nettype none

module ntas_mem #(
   parameter int WORDS = 8192,
   parameter int AW = $clog2(WORDS)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [63:0]   wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [63:0]   rdata
);

   logic [63:0] mem [WORDS];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/ntas_index.sv
// three-stage multiply chain: array element count and linear element index
// depends on ntas_pkg
`default_nettype none

module ntas_index
   import ntas_pkg::*;
#(
   parameter int IDX_W = 19
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire dim_vec_type       ext,
   input  wire dim_vec_type       koff,
   output logic                   done,
   output logic [TOT_W-1:0]       total,
   output logic [IDX_W-1:0]       idx
);

   logic vld1_ff, vld2_ff, vld3_ff;
   logic [2*DIM_W-1:0] st1_ff;
   logic [3*DIM_W-1:0] st2_ff;
   logic [4*DIM_W-1:0] st3_ff;
   logic [IDX_W-1:0]   acc1_ff, acc2_ff, acc3_ff;

   logic [2*DIM_W-1:0] p_st1, p_k1;
   logic [3*DIM_W-1:0] p_st2, p_k2;
   logic [4*DIM_W-1:0] p_st3, p_k3;

   assign p_st1 = ext[0] * ext[1];
   assign p_k1  = ext[0] * koff[1];
   assign p_st2 = st1_ff * ext[2];
   assign p_k2  = st1_ff * koff[2];
   assign p_st3 = st2_ff * ext[3];
   assign p_k3  = st2_ff * koff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= go;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff  <= p_st1;
      acc1_ff <= IDX_W'(koff[0]) + p_k1[IDX_W-1:0];
      st2_ff  <= p_st2;
      acc2_ff <= acc1_ff + p_k2[IDX_W-1:0];
      st3_ff  <= p_st3;
      acc3_ff <= acc2_ff + p_k3[IDX_W-1:0];
   end

   assign done  = vld3_ff;
   assign total = st3_ff;
   assign idx   = acc3_ff;

endmodule

`default_nettype wire

// File: sv/ndim_typed_array_store_core.sv
// top level of the n-dimensional typed array store: control sequencer and config registers
// depends on ntas_pkg, ntas_index and ntas_mem
//
// usage: an item (set, get or clear) is accepted at a clock edge with start high and busy
// low. req_coord_* are 1-based, the first coordinate is the fastest. every item yields one
// result on rsp_read_value / rsp_status, shown for exactly one cycle with rsp_strobe high;
// the receiver cannot stall and must take it then.
// sequence: a get or set passes three multiply stages for the element count and index,
// one memory read and one modify/write before its result; an error or no-op item returns
// its result straight after the multiply stages. busy drops with the result strobe, so no
// new item is accepted until the result of the previous item is out.
// a clear writes one memory word per cycle over the array, the last word by a
// read-modify-write when it is only partly covered.
// reset: config registers return to their defaults and the memory is zeroed by a pass over
// every memory word, one word per cycle; busy stays high during it. csr_* writes are taken
// in any cycle but are meant to be made only while no item is in flight.
`default_nettype none

module ndim_typed_array_store_core
   import ntas_pkg::*;
#(
   parameter int MEM_WORDS = DEF_MEM_WORDS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_func,
   input  wire logic [DIM_W-1:0]     req_coord_0,
   input  wire logic [DIM_W-1:0]     req_coord_1,
   input  wire logic [DIM_W-1:0]     req_coord_2,
   input  wire logic [DIM_W-1:0]     req_coord_3,
   input  wire logic [63:0]          req_elem_value,
   output logic                      rsp_strobe,
   output logic [63:0]               rsp_read_value,
   output logic [1:0]                rsp_status,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int PTR_W = AW + 1;
   localparam int IDX_W = AW + 6;
   localparam logic [TB_W-1:0] MEM_BITS = TB_W'(MEM_WORDS) << 6;
   localparam logic [PTR_W-1:0] LAST_WORD = PTR_W'(MEM_WORDS - 1);

   typedef enum logic [4:0] {
      S_INIT = 5'b00001,
      S_IDLE = 5'b00010,
      S_CALC = 5'b00100,
      S_FILL = 5'b01000,
      S_RMW  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]       elem_type_ff;
   logic [2:0]       num_dims_ff;
   dim_vec_type      dim_size_ff;

   logic [1:0]       func_ff;
   logic [63:0]      val_ff;
   logic             bad_ff;
   dim_vec_type      ext_ff, koff_ff;
   logic             go_ff;

   logic [PTR_W-1:0] clear_pointer_ff, clear_pointer_in;
   logic [PTR_W-1:0] fill_end_ff, fill_end_in;
   logic [5:0]       rem_ff, rem_in;
   logic [AW-1:0]    word_ff, word_in;
   logic [5:0]       sh_ff, sh_in;
   logic [63:0]      mask_ff, mask_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [63:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic             accept;
   logic [2:0]       nd;
   dim_vec_type      coord, ext_in, koff_in;
   logic             bad_in;

   logic             idx_done;
   logic [TOT_W-1:0] total;
   logic [IDX_W-1:0] idx;

   logic [2:0]       lg;
   logic [TB_W-1:0]  tb;
   logic [IDX_W-1:0] off;
   logic             too_large;
   logic [63:0]      pattern;

   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [63:0]      mem_wdata, mem_rdata;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_type_ff <= ET_S8;
         num_dims_ff  <= 3'd1;
         dim_size_ff  <= {REG_DIMS{DIM_W'(1)}};
      end else if (csr_we) begin
         unique case (csr_index)
            RI_ELEM_TYPE:  elem_type_ff   <= csr_wdata[3:0];
            RI_NUM_DIMS:   num_dims_ff    <= csr_wdata[2:0];
            RI_DIM_SIZE_0: dim_size_ff[0] <= csr_wdata;
            RI_DIM_SIZE_1: dim_size_ff[1] <= csr_wdata;
            RI_DIM_SIZE_2: dim_size_ff[2] <= csr_wdata;
            RI_DIM_SIZE_3: dim_size_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // extents and coordinate offsets of the dimensions in use, range check
   assign nd = (num_dims_ff > 3'(DIM_LIMIT)) ? 3'(DIM_LIMIT) : num_dims_ff;
   assign coord = {req_coord_3, req_coord_2, req_coord_1, req_coord_0};

   always_comb begin
      bad_in = 1'b0;
      for (int d = 0; d < REG_DIMS; d++) begin
         if (3'(d) < nd) begin
            ext_in[d]  = dim_size_ff[d];
            koff_in[d] = coord[d] - DIM_W'(1);
            if ((coord[d] == '0) || (coord[d] > dim_size_ff[d])) begin
               bad_in = 1'b1;
            end
         end else begin
            ext_in[d]  = DIM_W'(1);
            koff_in[d] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         val_ff  <= req_elem_value;
         bad_ff  <= bad_in;
         ext_ff  <= ext_in;
         koff_ff <= koff_in;
      end
   end

   ntas_index #(
      .IDX_W (IDX_W)
   ) u_index (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .ext   (ext_ff),
      .koff  (koff_ff),
      .done  (idx_done),
      .total (total),
      .idx   (idx)
   );

   assign lg        = type_lg(elem_type_ff);
   assign tb        = TB_W'(total) << lg;
   assign off       = idx << lg;
   assign too_large = (tb > MEM_BITS);
   assign pattern   = fill_pattern(elem_type_ff, val_ff);

   always_comb begin
      state_in         = state_ff;
      clear_pointer_in = clear_pointer_ff;
      fill_end_in      = fill_end_ff;
      rem_in           = rem_ff;
      word_in          = word_ff;
      sh_in            = sh_ff;
      mask_in          = mask_ff;
      rsp_strobe_in    = 1'b0;
      rsp_value_in     = '0;
      rsp_status_in    = ST_OK;
      mem_we           = 1'b0;
      mem_waddr        = clear_pointer_ff[AW-1:0];
      mem_wdata        = '0;
      mem_re           = 1'b0;
      mem_raddr        = clear_pointer_ff[AW-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            if (clear_pointer_ff == LAST_WORD) begin
               clear_pointer_in = '0;
               state_in         = S_IDLE;
            end else begin
               clear_pointer_in = clear_pointer_ff + PTR_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (idx_done) begin
               if ((func_ff == FN_NONE) || !type_known(elem_type_ff)) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else if (too_large) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_SIZE;
                  state_in      = S_IDLE;
               end else if (func_ff == FN_CLEAR) begin
                  fill_end_in      = tb[AW+6:6];
                  rem_in           = tb[5:0];
                  clear_pointer_in = '0;
                  state_in         = S_FILL;
               end else if (bad_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = off[IDX_W-1:6];
                  word_in   = off[IDX_W-1:6];
                  sh_in     = off[5:0];
                  mask_in   = width_mask(lg) << off[5:0];
                  state_in  = S_RMW;
               end
            end
         end
         S_FILL: begin
            if (clear_pointer_ff == fill_end_ff) begin
               if (rem_ff != 6'd0) begin
                  // last word only partly covered by the array
                  mem_re   = 1'b1;
                  word_in  = clear_pointer_ff[AW-1:0];
                  mask_in  = (64'd1 << rem_ff) - 64'd1;
                  state_in = S_RMW;
               end else begin
                  rsp_strobe_in    = 1'b1;
                  clear_pointer_in = '0;
                  state_in         = S_IDLE;
               end
            end else begin
               mem_we           = 1'b1;
               mem_wdata        = pattern;
               clear_pointer_in = clear_pointer_ff + PTR_W'(1);
            end
         end
         S_RMW: begin
            rsp_strobe_in    = 1'b1;
            clear_pointer_in = '0;
            state_in         = S_IDLE;
            mem_waddr        = word_ff;
            mem_wdata        = (mem_rdata & ~mask_ff) | (pattern & mask_ff);
            if (func_ff == FN_GET) begin
               rsp_value_in = extract_elem(elem_type_ff, mem_rdata, sh_ff);
            end else begin
               mem_we = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_INIT;
         clear_pointer_ff <= '0;
         go_ff            <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_pointer_ff <= clear_pointer_in;
         go_ff            <= accept;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_end_ff   <= fill_end_in;
      rem_ff        <= rem_in;
      word_ff       <= word_in;
      sh_ff         <= sh_in;
      mask_ff       <= mask_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   ntas_mem #(
      .WORDS (MEM_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire
